// File: hdl/ebcpu_pkg.sv
// Package for the 8-bit CPU execute unit: operation codes, flag positions
// and the transaction structs of the request and response channels.
// No dependencies.
package ebcpu_pkg;

   localparam int DATA_W = 8;
   localparam int KIND_W = 6;

   // Operation codes
   localparam logic [KIND_W-1:0] KIND_ADC   = 6'd0;
   localparam logic [KIND_W-1:0] KIND_SBC   = 6'd1;
   localparam logic [KIND_W-1:0] KIND_AND   = 6'd2;
   localparam logic [KIND_W-1:0] KIND_ORA   = 6'd3;
   localparam logic [KIND_W-1:0] KIND_EOR   = 6'd4;
   localparam logic [KIND_W-1:0] KIND_BIT   = 6'd5;
   localparam logic [KIND_W-1:0] KIND_CMP   = 6'd6;
   localparam logic [KIND_W-1:0] KIND_CPX   = 6'd7;
   localparam logic [KIND_W-1:0] KIND_CPY   = 6'd8;
   localparam logic [KIND_W-1:0] KIND_ASL_A = 6'd9;
   localparam logic [KIND_W-1:0] KIND_ASL_M = 6'd10;
   localparam logic [KIND_W-1:0] KIND_LSR_A = 6'd11;
   localparam logic [KIND_W-1:0] KIND_LSR_M = 6'd12;
   localparam logic [KIND_W-1:0] KIND_ROL_A = 6'd13;
   localparam logic [KIND_W-1:0] KIND_ROL_M = 6'd14;
   localparam logic [KIND_W-1:0] KIND_ROR_A = 6'd15;
   localparam logic [KIND_W-1:0] KIND_ROR_M = 6'd16;
   localparam logic [KIND_W-1:0] KIND_INC   = 6'd17;
   localparam logic [KIND_W-1:0] KIND_DEC   = 6'd18;
   localparam logic [KIND_W-1:0] KIND_INX   = 6'd19;
   localparam logic [KIND_W-1:0] KIND_INY   = 6'd20;
   localparam logic [KIND_W-1:0] KIND_DEX   = 6'd21;
   localparam logic [KIND_W-1:0] KIND_DEY   = 6'd22;
   localparam logic [KIND_W-1:0] KIND_LDA   = 6'd23;
   localparam logic [KIND_W-1:0] KIND_LDX   = 6'd24;
   localparam logic [KIND_W-1:0] KIND_LDY   = 6'd25;
   localparam logic [KIND_W-1:0] KIND_STA   = 6'd26;
   localparam logic [KIND_W-1:0] KIND_STX   = 6'd27;
   localparam logic [KIND_W-1:0] KIND_STY   = 6'd28;
   localparam logic [KIND_W-1:0] KIND_TAX   = 6'd29;
   localparam logic [KIND_W-1:0] KIND_TAY   = 6'd30;
   localparam logic [KIND_W-1:0] KIND_TXA   = 6'd31;
   localparam logic [KIND_W-1:0] KIND_TYA   = 6'd32;
   localparam logic [KIND_W-1:0] KIND_CLC   = 6'd33;
   localparam logic [KIND_W-1:0] KIND_SEC   = 6'd34;
   localparam logic [KIND_W-1:0] KIND_CLI   = 6'd35;
   localparam logic [KIND_W-1:0] KIND_SEI   = 6'd36;
   localparam logic [KIND_W-1:0] KIND_CLV   = 6'd37;
   localparam logic [KIND_W-1:0] KIND_CLD   = 6'd38;
   localparam logic [KIND_W-1:0] KIND_SED   = 6'd39;
   localparam logic [KIND_W-1:0] KIND_PHA   = 6'd40;
   localparam logic [KIND_W-1:0] KIND_PHP   = 6'd41;
   localparam logic [KIND_W-1:0] KIND_PLA   = 6'd42;
   localparam logic [KIND_W-1:0] KIND_PLP   = 6'd43;
   localparam logic [KIND_W-1:0] KIND_BPL   = 6'd44;
   localparam logic [KIND_W-1:0] KIND_BMI   = 6'd45;
   localparam logic [KIND_W-1:0] KIND_BVC   = 6'd46;
   localparam logic [KIND_W-1:0] KIND_BVS   = 6'd47;
   localparam logic [KIND_W-1:0] KIND_BCC   = 6'd48;
   localparam logic [KIND_W-1:0] KIND_BCS   = 6'd49;
   localparam logic [KIND_W-1:0] KIND_BNE   = 6'd50;
   localparam logic [KIND_W-1:0] KIND_BEQ   = 6'd51;
   localparam logic [KIND_W-1:0] KIND_NOP   = 6'd52;

   // Status bit positions: N V - B D I Z C
   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_I = 2;
   localparam int FLAG_D = 3;
   localparam int FLAG_B = 4;
   localparam int FLAG_U = 5;
   localparam int FLAG_V = 6;
   localparam int FLAG_N = 7;

   localparam logic [DATA_W-1:0] STATUS_MASK = 8'hDF;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [DATA_W-1:0] operand_byte;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]        acc_out;
      logic [DATA_W-1:0]        x_out;
      logic [DATA_W-1:0]        y_out;
      logic [DATA_W-1:0]        status_out;
      logic [DATA_W-1:0]        result_byte;
      logic                     write_back;
      logic                     branch_taken;
      logic signed [DATA_W-1:0] branch_offset;
   } rsp_type;

endpackage

// File: hdl/eight_bit_cpu_execute_unit_core.sv
// Execute unit of an 8-bit accumulator CPU: A, X, Y and status registers plus
// the ALU, shifter and branch-condition logic. Depends on ebcpu_pkg.
//
// One decoded operation per transaction on req_, one result per transaction on
// rsp_. Throughput is one transaction per clock while the response is not stalled.
// The request register loads at the accepting edge, the response register when
// that request executes, together with A, X, Y and status; a single ALU pass lies
// between the two registers. Transactions execute in order, each seeing the
// register state left by the one before. ADC and SBC are binary regardless of D;
// status bit five always reads 0. Opcodes 53 to 63 act as NOP. A stalled
// response holds the pipeline and the registers.
module eight_bit_cpu_execute_unit_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ebcpu_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ebcpu_pkg::rsp_type rsp_data
);
   import ebcpu_pkg::*;

   // request register
   logic    req_vld_ff, req_vld_in;
   req_type req_ff;
   // architectural state
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] x_ff, x_in;
   logic [DATA_W-1:0] y_ff, y_in;
   logic [DATA_W-1:0] st_ff, st_in;
   // response register
   logic    rsp_vld_ff, rsp_vld_in;
   rsp_type rsp_ff, rsp_in;

   logic req_accept;
   logic advance;

   // shift/rotate: returns {carry_out, result}
   function automatic logic [DATA_W:0] shift_fn(input logic [1:0] which,
                                                input logic [DATA_W-1:0] v,
                                                input logic cin);
      logic [DATA_W:0] r;
      unique case (which)
         2'd0:    r = {v[7], v[6:0], 1'b0};
         2'd1:    r = {v[0], 1'b0, v[7:1]};
         2'd2:    r = {v[7], v[6:0], cin};
         default: r = {v[0], cin, v[7:1]};
      endcase
      return r;
   endfunction

   assign advance    = req_vld_ff && !(rsp_vld_ff && rsp_stall);
   assign req_stall  = req_vld_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign req_vld_in = req_accept || (req_vld_ff && !advance);
   assign rsp_vld_in = advance || (rsp_vld_ff && rsp_stall);

   // ALU
   logic [DATA_W-1:0] m, m_add, nz_val, cmp_reg, sh_src, res, sh_res;
   logic [DATA_W:0]   sum, diff, sh_out;
   logic [1:0]        sh_sel;
   logic              nz_en, add_en, cmp_en, sh_en, wb, br, taken;

   always_comb begin
      m      = req_ff.operand_byte;
      m_add  = (req_ff.kind == KIND_SBC) ? ~m : m;
      sum    = {1'b0, acc_ff} + {1'b0, m_add} + {{DATA_W{1'b0}}, st_ff[FLAG_C]};
      unique case (req_ff.kind)
         KIND_CPX: cmp_reg = x_ff;
         KIND_CPY: cmp_reg = y_ff;
         default:  cmp_reg = acc_ff;
      endcase
      diff   = {1'b0, cmp_reg} - {1'b0, m};
      sh_sel = 2'((req_ff.kind - KIND_ASL_A) >> 1);
      sh_src = req_ff.kind[0] ? acc_ff : m;  // odd shift codes act on A
      sh_out = shift_fn(sh_sel, sh_src, st_ff[FLAG_C]);
      sh_res = sh_out[DATA_W-1:0];

      acc_in = acc_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      st_in  = st_ff;
      nz_en  = 1'b0;
      nz_val = '0;
      add_en = 1'b0;
      cmp_en = 1'b0;
      sh_en  = 1'b0;
      res    = '0;
      wb     = 1'b0;
      br     = 1'b0;
      taken  = 1'b0;

      unique case (req_ff.kind)
         KIND_ADC, KIND_SBC: begin
            add_en = 1'b1; acc_in = sum[DATA_W-1:0];
            nz_en = 1'b1; nz_val = sum[DATA_W-1:0];
         end
         KIND_AND: begin acc_in = acc_ff & m; nz_en = 1'b1; nz_val = acc_ff & m; end
         KIND_ORA: begin acc_in = acc_ff | m; nz_en = 1'b1; nz_val = acc_ff | m; end
         KIND_EOR: begin acc_in = acc_ff ^ m; nz_en = 1'b1; nz_val = acc_ff ^ m; end
         KIND_BIT: begin
            st_in[FLAG_Z] = ((acc_ff & m) == '0);
            st_in[FLAG_N] = m[7];
            st_in[FLAG_V] = m[6];
         end
         KIND_CMP, KIND_CPX, KIND_CPY: cmp_en = 1'b1;
         KIND_ASL_A, KIND_LSR_A, KIND_ROL_A, KIND_ROR_A: begin
            sh_en = 1'b1; acc_in = sh_res; nz_en = 1'b1; nz_val = sh_res;
         end
         KIND_ASL_M, KIND_LSR_M, KIND_ROL_M, KIND_ROR_M: begin
            sh_en = 1'b1; res = sh_res; wb = 1'b1; nz_en = 1'b1; nz_val = sh_res;
         end
         KIND_INC: begin res = m + 8'd1; wb = 1'b1; nz_en = 1'b1; nz_val = m + 8'd1; end
         KIND_DEC: begin res = m - 8'd1; wb = 1'b1; nz_en = 1'b1; nz_val = m - 8'd1; end
         KIND_INX: begin x_in = x_ff + 8'd1; nz_en = 1'b1; nz_val = x_ff + 8'd1; end
         KIND_INY: begin y_in = y_ff + 8'd1; nz_en = 1'b1; nz_val = y_ff + 8'd1; end
         KIND_DEX: begin x_in = x_ff - 8'd1; nz_en = 1'b1; nz_val = x_ff - 8'd1; end
         KIND_DEY: begin y_in = y_ff - 8'd1; nz_en = 1'b1; nz_val = y_ff - 8'd1; end
         KIND_LDA, KIND_PLA: begin acc_in = m; nz_en = 1'b1; nz_val = m; end
         KIND_LDX: begin x_in = m; nz_en = 1'b1; nz_val = m; end
         KIND_LDY: begin y_in = m; nz_en = 1'b1; nz_val = m; end
         KIND_STA, KIND_PHA: begin res = acc_ff; wb = 1'b1; end
         KIND_STX: begin res = x_ff; wb = 1'b1; end
         KIND_STY: begin res = y_ff; wb = 1'b1; end
         KIND_TAX: begin x_in = acc_ff; nz_en = 1'b1; nz_val = acc_ff; end
         KIND_TAY: begin y_in = acc_ff; nz_en = 1'b1; nz_val = acc_ff; end
         KIND_TXA: begin acc_in = x_ff; nz_en = 1'b1; nz_val = x_ff; end
         KIND_TYA: begin acc_in = y_ff; nz_en = 1'b1; nz_val = y_ff; end
         KIND_CLC: st_in[FLAG_C] = 1'b0;
         KIND_SEC: st_in[FLAG_C] = 1'b1;
         KIND_CLI: st_in[FLAG_I] = 1'b0;
         KIND_SEI: st_in[FLAG_I] = 1'b1;
         KIND_CLV: st_in[FLAG_V] = 1'b0;
         KIND_CLD: st_in[FLAG_D] = 1'b0;
         KIND_SED: st_in[FLAG_D] = 1'b1;
         KIND_PHP: begin res = st_ff & STATUS_MASK; wb = 1'b1; end
         KIND_PLP: st_in = m;
         KIND_BPL: begin br = 1'b1; taken = !st_ff[FLAG_N]; end
         KIND_BMI: begin br = 1'b1; taken =  st_ff[FLAG_N]; end
         KIND_BVC: begin br = 1'b1; taken = !st_ff[FLAG_V]; end
         KIND_BVS: begin br = 1'b1; taken =  st_ff[FLAG_V]; end
         KIND_BCC: begin br = 1'b1; taken = !st_ff[FLAG_C]; end
         KIND_BCS: begin br = 1'b1; taken =  st_ff[FLAG_C]; end
         KIND_BNE: begin br = 1'b1; taken = !st_ff[FLAG_Z]; end
         KIND_BEQ: begin br = 1'b1; taken =  st_ff[FLAG_Z]; end
         default: ;  // NOP and unused codes
      endcase

      if (add_en) begin
         st_in[FLAG_C] = sum[DATA_W];
         st_in[FLAG_V] = (~(acc_ff[7] ^ m_add[7])) & (acc_ff[7] ^ sum[7]);
      end
      if (cmp_en) begin
         st_in[FLAG_C] = !diff[DATA_W];
         st_in[FLAG_Z] = (cmp_reg == m);
         st_in[FLAG_N] = diff[7];
      end
      if (sh_en) begin
         st_in[FLAG_C] = sh_out[DATA_W];
      end
      if (nz_en) begin
         st_in[FLAG_Z] = (nz_val == '0);
         st_in[FLAG_N] = nz_val[7];
      end
      st_in[FLAG_U] = 1'b0;

      rsp_in.acc_out       = acc_in;
      rsp_in.x_out         = x_in;
      rsp_in.y_out         = y_in;
      rsp_in.status_out    = st_in;
      rsp_in.result_byte   = res;
      rsp_in.write_back    = wb;
      rsp_in.branch_taken  = taken;
      rsp_in.branch_offset = br ? signed'(m) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         acc_ff     <= '0;
         x_ff       <= '0;
         y_ff       <= '0;
         st_ff      <= '0;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (advance) begin
            acc_ff <= acc_in;
            x_ff   <= x_in;
            y_ff   <= y_in;
            st_ff  <= st_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   a_unused_flag_zero: assert property (@(posedge clock) disable iff (reset)
      st_ff[FLAG_U] == 1'b0)
      else $error("status bit five set");

   a_advance_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_vld_ff)
      else $error("executed transaction produced no response");

   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(acc_ff) && $stable(x_ff) && $stable(y_ff) && $stable(st_ff)))
      else $error("register state changed without executing a transaction");

   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_ff.acc_out == acc_ff && rsp_ff.x_out == x_ff
                   && rsp_ff.y_out == y_ff && rsp_ff.status_out == st_ff))
      else $error("response registers disagree with register state");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (req_vld_ff && rsp_vld_ff))
      else $error("request stalled with nothing blocking");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Testbench for eight_bit_cpu_execute_unit_core: streams decoded operations with
// random idle and stall, predicts registers, status, write-back and branch result
// per transaction and checks them in order. Depends on ebcpu_pkg and the core.
module tb;
   import ebcpu_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT    = 11;
   localparam int DRAIN_WAIT  = 8;

   // codes past NOP decode as NOP
   localparam logic [KIND_W-1:0] KIND_SPARE_LO = KIND_NOP + 6'd1;
   localparam logic [KIND_W-1:0] KIND_SPARE_HI = 6'd63;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // predicted architectural state
   logic [DATA_W-1:0] acc_m, x_m, y_m, p_m;

   rsp_type exec_results_due[$];
   int      error_count = 0;
   int      cycle_count = 0;
   int      stall_hold  = 0;
   bit      idling_on   = 1'b1;

   eight_bit_cpu_execute_unit_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d transactions outstanding",
                  cycle_count, exec_results_due.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor
   function automatic void put_nz(input logic [DATA_W-1:0] v);
      p_m[FLAG_Z] = (v == 8'h00);
      p_m[FLAG_N] = v[7];
   endfunction

   function automatic void put_compare(input logic [DATA_W-1:0] r,
                                       input logic [DATA_W-1:0] m);
      logic [DATA_W-1:0] diff;
      diff = r - m;
      p_m[FLAG_C] = (r >= m);
      p_m[FLAG_Z] = (r == m);
      p_m[FLAG_N] = diff[7];
   endfunction

   function automatic logic [DATA_W-1:0] shift_byte(input logic [KIND_W-1:0] kind,
                                                    input logic [DATA_W-1:0] v);
      logic              cin;
      logic [DATA_W-1:0] r;
      cin = p_m[FLAG_C];
      case (kind)
         KIND_ASL_A, KIND_ASL_M: begin
            p_m[FLAG_C] = v[7];
            r = {v[6:0], 1'b0};
         end
         KIND_LSR_A, KIND_LSR_M: begin
            p_m[FLAG_C] = v[0];
            r = {1'b0, v[7:1]};
         end
         KIND_ROL_A, KIND_ROL_M: begin
            p_m[FLAG_C] = v[7];
            r = {v[6:0], cin};
         end
         default: begin
            p_m[FLAG_C] = v[0];
            r = {cin, v[7:1]};
         end
      endcase
      put_nz(r);
      return r;
   endfunction

   function automatic rsp_type compute_exec(input req_type item);
      logic [DATA_W-1:0] m, addend, res, prior;
      logic [DATA_W:0]   sum;
      logic              wb, br, taken;
      rsp_type           o;
      m     = item.operand_byte;
      res   = '0;
      wb    = 1'b0;
      br    = 1'b0;
      taken = 1'b0;
      prior = p_m;
      case (item.kind)
         KIND_ADC, KIND_SBC: begin
            // SBC is ADC of the complement; always binary
            addend = (item.kind == KIND_SBC) ? ~m : m;
            sum = {1'b0, acc_m} + {1'b0, addend} + {8'h00, p_m[FLAG_C]};
            p_m[FLAG_V] = (acc_m[7] == addend[7]) && (sum[7] != acc_m[7]);
            p_m[FLAG_C] = sum[8];
            acc_m = sum[7:0];
            put_nz(acc_m);
         end
         KIND_AND: begin acc_m = acc_m & m; put_nz(acc_m); end
         KIND_ORA: begin acc_m = acc_m | m; put_nz(acc_m); end
         KIND_EOR: begin acc_m = acc_m ^ m; put_nz(acc_m); end
         KIND_BIT: begin
            p_m[FLAG_Z] = ((acc_m & m) == 8'h00);
            p_m[FLAG_N] = m[7];
            p_m[FLAG_V] = m[6];
         end
         KIND_CMP: put_compare(acc_m, m);
         KIND_CPX: put_compare(x_m, m);
         KIND_CPY: put_compare(y_m, m);
         KIND_ASL_A, KIND_LSR_A, KIND_ROL_A, KIND_ROR_A: acc_m = shift_byte(item.kind, acc_m);
         KIND_ASL_M, KIND_LSR_M, KIND_ROL_M, KIND_ROR_M: begin
            res = shift_byte(item.kind, m);
            wb  = 1'b1;
         end
         KIND_INC: begin res = m + 8'd1; put_nz(res); wb = 1'b1; end
         KIND_DEC: begin res = m - 8'd1; put_nz(res); wb = 1'b1; end
         KIND_INX: begin x_m = x_m + 8'd1; put_nz(x_m); end
         KIND_INY: begin y_m = y_m + 8'd1; put_nz(y_m); end
         KIND_DEX: begin x_m = x_m - 8'd1; put_nz(x_m); end
         KIND_DEY: begin y_m = y_m - 8'd1; put_nz(y_m); end
         KIND_LDA, KIND_PLA: begin acc_m = m; put_nz(acc_m); end
         KIND_LDX: begin x_m = m; put_nz(x_m); end
         KIND_LDY: begin y_m = m; put_nz(y_m); end
         KIND_STA, KIND_PHA: begin res = acc_m; wb = 1'b1; end
         KIND_STX: begin res = x_m; wb = 1'b1; end
         KIND_STY: begin res = y_m; wb = 1'b1; end
         KIND_TAX: begin x_m = acc_m; put_nz(x_m); end
         KIND_TAY: begin y_m = acc_m; put_nz(y_m); end
         KIND_TXA: begin acc_m = x_m; put_nz(acc_m); end
         KIND_TYA: begin acc_m = y_m; put_nz(acc_m); end
         KIND_CLC: p_m[FLAG_C] = 1'b0;
         KIND_SEC: p_m[FLAG_C] = 1'b1;
         KIND_CLI: p_m[FLAG_I] = 1'b0;
         KIND_SEI: p_m[FLAG_I] = 1'b1;
         KIND_CLV: p_m[FLAG_V] = 1'b0;
         KIND_CLD: p_m[FLAG_D] = 1'b0;
         KIND_SED: p_m[FLAG_D] = 1'b1;
         KIND_PHP: begin res = p_m & STATUS_MASK; wb = 1'b1; end
         KIND_PLP: p_m = m & STATUS_MASK;
         KIND_BPL: begin br = 1'b1; taken = !prior[FLAG_N]; end
         KIND_BMI: begin br = 1'b1; taken =  prior[FLAG_N]; end
         KIND_BVC: begin br = 1'b1; taken = !prior[FLAG_V]; end
         KIND_BVS: begin br = 1'b1; taken =  prior[FLAG_V]; end
         KIND_BCC: begin br = 1'b1; taken = !prior[FLAG_C]; end
         KIND_BCS: begin br = 1'b1; taken =  prior[FLAG_C]; end
         KIND_BNE: begin br = 1'b1; taken = !prior[FLAG_Z]; end
         KIND_BEQ: begin br = 1'b1; taken =  prior[FLAG_Z]; end
         default: ;
      endcase
      p_m = p_m & STATUS_MASK;
      o.acc_out       = acc_m;
      o.x_out         = x_m;
      o.y_out         = y_m;
      o.status_out    = p_m;
      o.result_byte   = wb ? res : 8'h00;
      o.write_back    = wb;
      o.branch_taken  = taken;
      o.branch_offset = br ? m : 8'h00;
      return o;
   endfunction

   // ------------------------------------------------------------------ checking
   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      $display("ERROR @%0t %s: got %h expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic check_field(input string what, input logic [DATA_W-1:0] got,
                              input logic [DATA_W-1:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (exec_results_due.size() == 0) begin
            report_mismatch("unexpected transaction, acc_out", rsp_data.acc_out, 8'h00);
         end else begin
            want = exec_results_due.pop_front();
            check_field("acc_out",       rsp_data.acc_out,       want.acc_out);
            check_field("x_out",         rsp_data.x_out,         want.x_out);
            check_field("y_out",         rsp_data.y_out,         want.y_out);
            check_field("status_out",    rsp_data.status_out,    want.status_out);
            check_field("result_byte",   rsp_data.result_byte,   want.result_byte);
            check_field("write_back",    {7'd0, rsp_data.write_back},   {7'd0, want.write_back});
            check_field("branch_taken",  {7'd0, rsp_data.branch_taken}, {7'd0, want.branch_taken});
            check_field("branch_offset", rsp_data.branch_offset, want.branch_offset);
         end
      end
   end

   // response-side back-pressure, now and then held for a short stretch
   always @(negedge clock) begin
      if (reset || !idling_on) begin
         rsp_stall = 1'b0;
         stall_hold = 0;
      end else if (stall_hold > 0) begin
         rsp_stall = 1'b1;
         stall_hold--;
      end else if ($urandom_range(99) < IDLE_PCT) begin
         rsp_stall = 1'b1;
         if ($urandom_range(31) == 0)
            stall_hold = $urandom_range(6, 2);
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // ------------------------------------------------------------------ stimulus
   // valid stays high into the next call; it drops only in an idle gap or when results are drained
   task automatic send_op(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] opnd);
      req_type item;
      item.kind = kind;
      item.operand_byte = opnd;
      @(negedge clock);
      while (idling_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      exec_results_due.push_back(compute_exec(item));
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (exec_results_due.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [KIND_W-1:0] rand_kind();
      if ($urandom_range(11) == 0)
         return KIND_W'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
      return KIND_W'($urandom_range(KIND_NOP));
   endfunction

   function automatic logic [DATA_W-1:0] rand_operand();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return ($urandom_range(1) == 0) ? 8'h7F : 8'h80;
         default: return DATA_W'($urandom_range(255));
      endcase
   endfunction

   task automatic test_directed();
      send_op(KIND_LDA, 8'h7F);
      send_op(KIND_ADC, 8'h01);       // signed overflow into negative
      send_op(KIND_BVS, 8'h80);       // taken, most negative offset
      send_op(KIND_BMI, 8'h7F);
      send_op(KIND_LDA, 8'hFF);
      send_op(KIND_SEC, 8'h00);
      send_op(KIND_ADC, 8'hFF);       // carry out with carry in
      send_op(KIND_BCS, 8'h01);
      send_op(KIND_SBC, 8'h80);
      send_op(KIND_SED, 8'h00);
      send_op(KIND_ADC, 8'h09);       // binary even with D set
      send_op(KIND_LDA, 8'h00);
      send_op(KIND_BIT, 8'hFF);       // zero result, N and V from operand
      send_op(KIND_CMP, 8'h00);       // equal
      send_op(KIND_LDX, 8'hFF);
      send_op(KIND_INX, 8'h00);       // wraps to zero
      send_op(KIND_CPX, 8'h01);       // register below operand
      send_op(KIND_LDY, 8'h00);
      send_op(KIND_DEY, 8'h00);       // wraps to FF
      send_op(KIND_PLP, 8'hFF);       // bit five must not stick
      send_op(KIND_PHP, 8'h00);
      send_op(KIND_ROR_M, 8'h01);
      send_op(KIND_INC, 8'hFF);
      send_op(KIND_DEC, 8'h00);
      send_op(KIND_SPARE_HI, 8'hFF);
      send_op(KIND_SEI, 8'h00);
   endtask

   task automatic test_kind_sweep();
      for (int k = 0; k < 2**KIND_W; k++)
         send_op(KIND_W'(k), DATA_W'($urandom_range(255)));
   endtask

   task automatic test_random_stream(input int count);
      for (int i = 0; i < count; i++)
         send_op(rand_kind(), rand_operand());
   endtask

   task automatic test_drain_pause();
      for (int r = 0; r < 4; r++) begin
         test_random_stream(20);
         drain_results();
         test_random_stream(20);
      end
   endtask

   task automatic test_back_to_back();
      idling_on = 1'b0;
      test_random_stream(300);
      idling_on = 1'b1;
   endtask

   initial begin
      acc_m = '0;
      x_m   = '0;
      y_m   = '0;
      p_m   = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_kind_sweep();
      test_random_stream(900);
      test_drain_pause();
      test_back_to_back();
      test_random_stream(150);

      drain_results();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: filelist.f
hdl/ebcpu_pkg.sv
hdl/eight_bit_cpu_execute_unit_core.sv
sim/tb.sv
